FILE: src/nsba_pkg.sv
// Package for the NAT sequence block allocator.
// Shared widths, function codes, register indexes and transfer structs.
// No dependencies.
package nsba_pkg;

    localparam int ENTRIES   = 1024;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int SEQ_W     = 16;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int DATA_W    = 2 * SEQ_W;

    localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ASSIGN = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SHARE_FACTOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 1'd1;

    localparam logic [SEQ_W-1:0] SHARE_FACTOR_RST = 16'd1;
    localparam logic [SEQ_W-1:0] BLOCK_SIZE_RST   = 16'd65535;

    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_NO_ENTRY = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  entry_index;
    } t_in;

    typedef struct packed {
        logic             status;
        logic [SEQ_W-1:0] sequence_out;
        logic [SEQ_W-1:0] range_low;
        logic [SEQ_W-1:0] range_high;
    } t_out;

    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] dividend;
        logic [SEQ_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] remainder;
    } t_mod_rsp;

endpackage

FILE: src/nsba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module nsba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/nsba_mod.sv
// Bit-serial remainder unit: entry index modulo share factor, one bit a cycle.
// Depends on nsba_pkg.
module nsba_mod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nsba_pkg::t_mod_req i_req,
    output nsba_pkg::t_mod_rsp o_rsp
);

    localparam int CNT_W = $clog2(nsba_pkg::IDX_W);
    localparam int IW    = nsba_pkg::IDX_W;
    localparam int SW    = nsba_pkg::SEQ_W;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [IW-1:0]    r_num;
    logic [IW-1:0]    r_rem;
    logic [SW-1:0]    r_div;

    logic [IW:0]      w_shift;
    logic             w_ge;
    logic [IW:0]      w_diff;

    // partial remainder never exceeds the partial dividend, so IW+1 bits do
    assign w_shift = {r_rem, r_num[IW-1]};
    assign w_ge    = ({{(SW-IW-1){1'b0}}, w_shift} >= r_div);
    assign w_diff  = w_shift - r_div[IW:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(IW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= '0;
            r_num <= i_req.dividend;
            r_rem <= '0;
            // a zero share factor counts as one
            r_div <= (i_req.divisor == '0) ? SW'(1) : i_req.divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            r_num <= {r_num[IW-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[IW-1:0] : w_shift[IW-1:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ({{(SW-IW){1'b0}}, r_rem} < r_div))
        else $error("remainder not below divisor");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("remainder unit restarted while busy");

endmodule

FILE: src/nat_sequence_block_allocator.sv
// Top level of the NAT ICMP sequence block allocator.
// Depends on nsba_pkg, nsba_ram and nsba_mod.
//
// Usage:
// - Input channel (i_in_valid / o_in_stall, payload i_in): one command per
//   transfer: create, delete, assign or query on an entry index.
// - Output channel (o_out_valid / i_out_stall, payload o_out): exactly one
//   result per command, in command order.
// - Config port (i_cfg_we, i_cfg_index, i_cfg_data): share factor and block
//   size; write only while no command is in flight.
// - Path, accept to result valid: delete, assign and query pass the RAM
//   read, the result register and the output register; create passes the
//   RAM read and the bit-serial remainder (one index bit a cycle, 10 bits,
//   started at the accept), sees its done flag and latches the product, then
//   the write-back, the result register and the output register.
// - One command at a time: a new one is taken only once the last has left
//   S_RESP for the output register. All entry state sits in two RAMs with
//   registered read; each command reads one entry and may write it back.
// - Reset: a clearing pass writes every entry of the valid RAM, one entry a
//   cycle, with o_in_stall high. Config writes are taken throughout.
// - Receiver stall: the output register holds its result; the block still
//   takes and works on the next command and waits with that result until
//   the output register frees.
module nat_sequence_block_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [nsba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nsba_pkg::SEQ_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  nsba_pkg::t_in                      i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output nsba_pkg::t_out                     o_out
);

    localparam int IW = nsba_pkg::IDX_W;
    localparam int SW = nsba_pkg::SEQ_W;

    // controller states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_CRT   = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]                  r_state;
    logic [2:0]                  n_state;
    logic [IW-1:0]               r_clr_cnt;
    logic [SW-1:0]               r_share_factor;
    logic [SW-1:0]               r_block_size;
    logic [nsba_pkg::FUNC_W-1:0] r_func;
    logic [IW-1:0]               r_idx;
    logic [SW-1:0]               r_low;
    nsba_pkg::t_out              r_res;
    nsba_pkg::t_out              n_res;
    logic                        r_out_valid;
    nsba_pkg::t_out              r_out;

    logic                        w_accept;
    logic                        w_out_load;
    logic                        w_rd_valid;
    logic [nsba_pkg::DATA_W-1:0] w_rd_data;
    logic [SW-1:0]               w_rd_low;
    logic [SW-1:0]               w_rd_seq;
    logic [SW-1:0]               w_rd_high;
    logic [SW-1:0]               w_crt_high;
    logic [SW-1:0]               w_seq_next;
    logic [IW+SW-1:0]            w_prod;

    logic                        w_v_we;
    logic [IW-1:0]               w_v_waddr;
    logic                        w_v_wdata;
    logic                        w_d_we;
    logic [nsba_pkg::DATA_W-1:0] w_d_wdata;

    nsba_pkg::t_mod_req          w_mod_req;
    nsba_pkg::t_mod_rsp          w_mod_rsp;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_load = (r_state == S_RESP) && (!r_out_valid || !i_out_stall);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_share_factor <= nsba_pkg::SHARE_FACTOR_RST;
            r_block_size   <= nsba_pkg::BLOCK_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                nsba_pkg::REG_SHARE_FACTOR: r_share_factor <= i_cfg_data;
                nsba_pkg::REG_BLOCK_SIZE:   r_block_size   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // entry RAMs: valid mark alone (cleared after reset), low and sequence
    // together (never cleared, only read behind a set valid mark)
    nsba_ram #(
        .WIDTH (1),
        .DEPTH (nsba_pkg::ENTRIES)
    ) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (w_v_we),
        .i_waddr (w_v_waddr),
        .i_wdata (w_v_wdata),
        .i_raddr (i_in.entry_index),
        .o_rdata (w_rd_valid)
    );

    nsba_ram #(
        .WIDTH (nsba_pkg::DATA_W),
        .DEPTH (nsba_pkg::ENTRIES)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (r_idx),
        .i_wdata (w_d_wdata),
        .i_raddr (i_in.entry_index),
        .o_rdata (w_rd_data)
    );

    // read data in S_READ belongs to the index taken at the accept edge;
    // every write lands before the next accept, so no forwarding is needed
    assign w_rd_low = w_rd_data[nsba_pkg::DATA_W-1:SW];
    assign w_rd_seq = w_rd_data[SW-1:0];

    // high end is low + size - 1, mod 2^16, from the current block size
    assign w_rd_high  = w_rd_low + r_block_size - SW'(1);
    assign w_crt_high = r_low + r_block_size - SW'(1);
    assign w_seq_next = (w_rd_seq >= w_rd_high) ? w_rd_low : w_rd_seq + SW'(1);

    assign w_prod = {{SW{1'b0}}, w_mod_rsp.remainder} * {{IW{1'b0}}, r_block_size};

    // remainder of the index over the share factor, only for create
    assign w_mod_req.start    = w_accept && (i_in.func == nsba_pkg::FUNC_CREATE);
    assign w_mod_req.dividend = i_in.entry_index;
    assign w_mod_req.divisor  = r_share_factor;

    nsba_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_rsp   (w_mod_rsp)
    );

    // RAM write ports
    always_comb begin
        w_v_we    = 1'b0;
        w_v_waddr = r_idx;
        w_v_wdata = 1'b0;
        w_d_we    = 1'b0;
        w_d_wdata = {w_rd_low, w_seq_next};
        unique case (r_state)
            S_CLEAR: begin
                w_v_we    = 1'b1;
                w_v_waddr = r_clr_cnt;
            end
            S_READ: begin
                w_v_we = (r_func == nsba_pkg::FUNC_DELETE);
                w_d_we = (r_func == nsba_pkg::FUNC_ASSIGN) && w_rd_valid;
            end
            S_CRT: begin
                w_v_we    = 1'b1;
                w_v_wdata = 1'b1;
                w_d_we    = 1'b1;
                w_d_wdata = {r_low, r_low};
            end
            default: ;
        endcase
    end

    // next state and result
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == IW'(nsba_pkg::ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_res = '0;
                if (r_func == nsba_pkg::FUNC_CREATE) begin
                    n_state = S_MOD;
                end else begin
                    n_state = S_RESP;
                    if (r_func != nsba_pkg::FUNC_DELETE) begin
                        if (!w_rd_valid) begin
                            n_res.status = nsba_pkg::STATUS_NO_ENTRY;
                        end else begin
                            n_res.range_low  = w_rd_low;
                            n_res.range_high = w_rd_high;
                            if (r_func == nsba_pkg::FUNC_ASSIGN) begin
                                n_res.sequence_out = w_rd_seq;
                            end
                        end
                    end
                end
            end
            S_MOD: begin
                if (w_mod_rsp.done) begin
                    n_state = S_CRT;
                end
            end
            S_CRT: begin
                n_res            = '0;
                n_res.range_low  = r_low;
                n_res.range_high = w_crt_high;
                n_state          = S_RESP;
            end
            S_RESP: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + IW'(1);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_in.func;
            r_idx  <= i_in.entry_index;
        end
        if (r_state == S_MOD && w_mod_rsp.done) begin
            r_low <= w_prod[SW-1:0];
        end
        r_res <= n_res;
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("command taken during clearing pass");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_READ))
        else $error("accepted command did not start a read");

    a_mod_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_rsp.done |-> (r_state == S_MOD))
        else $error("remainder finished outside create");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> ($past(r_state) == S_RESP))
        else $error("result transfer not from response state");

endmodule

FILE: tb/nsba_checker.sv
// Scoreboard for the NAT sequence block allocator: watches the config port and
// both transfer channels, predicts each result and compares it field by field.
// Depends on nsba_pkg.
`timescale 1ns / 1ps

module nsba_checker
    import nsba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SEQ_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in                  i_in,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out                 i_out,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    // own copy of the allocator state
    logic [SEQ_W-1:0] share_factor;
    logic [SEQ_W-1:0] block_size;
    bit               entry_live [ENTRIES];
    logic [SEQ_W-1:0] entry_low  [ENTRIES];
    logic [SEQ_W-1:0] entry_next [ENTRIES];

    t_out pending_results [$];

    // counters are int, so they start at zero

    // top of the block, always from the current block size (16-bit wrap)
    function automatic logic [SEQ_W-1:0] block_high(input logic [SEQ_W-1:0] low);
        block_high = low + block_size - 16'd1;
    endfunction

    function automatic t_out predict_allocation(input t_in cmd);
        t_out             res;
        int unsigned      k;
        int unsigned      prod;
        logic [SEQ_W-1:0] low;
        logic [SEQ_W-1:0] high;
        res = '0;
        res.status = STATUS_DONE;
        case (cmd.func)
            FUNC_CREATE: begin
                k    = (share_factor == '0) ? 1 : share_factor;
                prod = (cmd.entry_index % k) * block_size;
                low  = prod[SEQ_W-1:0];
                entry_live[cmd.entry_index] = 1'b1;
                entry_low[cmd.entry_index]  = low;
                entry_next[cmd.entry_index] = low;
                res.range_low  = low;
                res.range_high = block_high(low);
            end
            FUNC_DELETE: begin
                entry_live[cmd.entry_index] = 1'b0;
            end
            default: begin
                if (!entry_live[cmd.entry_index]) begin
                    res.status = STATUS_NO_ENTRY;
                end else begin
                    low  = entry_low[cmd.entry_index];
                    high = block_high(low);
                    res.range_low  = low;
                    res.range_high = high;
                    if (cmd.func == FUNC_ASSIGN) begin
                        res.sequence_out = entry_next[cmd.entry_index];
                        if (entry_next[cmd.entry_index] >= high)
                            entry_next[cmd.entry_index] = low;
                        else
                            entry_next[cmd.entry_index] = entry_next[cmd.entry_index] + 16'd1;
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input logic [SEQ_W-1:0] want,
                               input logic [SEQ_W-1:0] got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
                     $time, name, want, want, got, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            share_factor = SHARE_FACTOR_RST;
            block_size   = BLOCK_SIZE_RST;
            foreach (entry_live[i])
                entry_live[i] = 1'b0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SHARE_FACTOR: share_factor = i_cfg_data;
                    REG_BLOCK_SIZE:   block_size   = i_cfg_data;
                    default: ;
                endcase
            end
            // result side first: a result never belongs to a command taken
            // on the same edge
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result with nothing outstanding, got %h", $time, i_out);
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", SEQ_W'(want.status), SEQ_W'(i_out.status));
                    check_field("sequence_out", want.sequence_out, i_out.sequence_out);
                    check_field("range_low", want.range_low, i_out.range_low);
                    check_field("range_high", want.range_high, i_out.range_high);
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_results.push_back(predict_allocation(i_in));
        end
        o_pending = pending_results.size();
    end

endmodule

FILE: tb/nat_sequence_block_allocator_tb.sv
// Top of the allocator testbench: clock, reset, command stimulus, receiver
// back-pressure, watchdog and verdict. Depends on nsba_pkg, nsba_checker
// and the nat_sequence_block_allocator RTL.
`timescale 1ns / 1ps

module nat_sequence_block_allocator_tb;
    import nsba_pkg::*;

    // Longest quiet spell in a correct run is the clearing pass after reset;
    // the long receiver hold-off is shorter. Several times over.
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int HOLD_CYCLES    = 300;
    localparam int CREATE_LATENCY = 13;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 215;
    localparam int NUM_PHASES     = 5;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SEQ_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    t_in                  in_payload;
    logic                 out_valid;
    logic                 out_stall;
    t_out                 out_payload;

    int fail_count;
    int pending;
    int checked;

    int  cmds_sent    = 0;
    int  cfg_writes   = 0;
    int  holds_done   = 0;
    int  idle_cycles  = 0;
    bit  quiet        = 1'b0;   // no idling on either side in the last phase
    bit  hold_req     = 1'b0;   // asks the receiver for one long hold-off

    nat_sequence_block_allocator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_payload),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_payload)
    );

    nsba_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_payload),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_payload),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
            $display("nat_sequence_block_allocator_tb: done, errors");
            $finish;
        end
    end

    // Receiver: stretches of free flow and random stall bursts,
    // plus one long hold-off on request so the block backs up onto its input.
    initial begin
        out_stall = 1'b0;
        forever begin
            if (hold_req && holds_done == 0) begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end else begin
                out_stall = 1'b0;
                repeat ($urandom_range(1, quiet ? 1 : 20)) @(negedge clk);
            end
        end
    end

    // One command transfer. Called just after a falling edge; returns just
    // after the falling edge that follows acceptance with valid still high,
    // so back-to-back commands keep valid up.
    task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] idx);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid   = 1'b1;
        in_payload = '{func: func, entry_index: idx};
        do @(posedge clk); while (in_stall);
        cmds_sent++;
        @(negedge clk);
    endtask

    // Wait until every result is back, then give a create's latency more.
    task automatic drain_block;
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (CREATE_LATENCY) @(negedge clk);
    endtask

    // Both registers, only with the block idle.
    task automatic set_config(input logic [SEQ_W-1:0] sf, input logic [SEQ_W-1:0] bs);
        drain_block();
        cfg_we    = 1'b1;
        cfg_index = REG_SHARE_FACTOR;
        cfg_data  = sf;
        @(negedge clk);
        cfg_index = REG_BLOCK_SIZE;
        cfg_data  = bs;
        @(negedge clk);
        cfg_we = 1'b0;
        cfg_writes += 2;
    endtask

    // Mostly well-formed traffic on a small pool of slots so that creates
    // come before assigns and blocks wrap; now and then any slot at all.
    task automatic run_random(input int count);
        logic [IDX_W-1:0]  pool [8];
        logic [IDX_W-1:0]  idx;
        logic [FUNC_W-1:0] func;
        int                r;
        foreach (pool[i])
            pool[i] = IDX_W'($urandom_range(0, ENTRIES - 1));
        pool[0] = ($urandom_range(0, 1) == 0) ? '0 : '1;
        for (int n = 0; n < count; n++) begin
            r   = $urandom_range(0, 99);
            idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, ENTRIES - 1))
                                              : pool[$urandom_range(0, 7)];
            if (r < 15)      func = FUNC_CREATE;
            else if (r < 25) func = FUNC_DELETE;
            else if (r < 75) func = FUNC_ASSIGN;
            else             func = FUNC_QUERY;
            send_cmd(func, idx);
        end
    endtask

    initial begin
        logic [SEQ_W-1:0] sf_set [NUM_PHASES];
        logic [SEQ_W-1:0] bs_set [NUM_PHASES];
        int               rnd_sf;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_SHARE_FACTOR;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_payload = '0;
        // reset held over the first rising edges, released at a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed, reset settings (share 1, block 65535) ---
        send_cmd(FUNC_QUERY, 10'd0);       // missing entry
        send_cmd(FUNC_ASSIGN, 10'd1023);   // missing entry
        send_cmd(FUNC_DELETE, 10'd5);      // delete of a missing entry is fine
        send_cmd(FUNC_CREATE, 10'd0);
        send_cmd(FUNC_ASSIGN, 10'd0);
        send_cmd(FUNC_ASSIGN, 10'd0);
        send_cmd(FUNC_QUERY, 10'd0);
        send_cmd(FUNC_CREATE, 10'd1023);

        // small blocks: wrap from high back to low, re-create, delete
        set_config(16'd4, 16'd3);
        send_cmd(FUNC_CREATE, 10'd7);
        repeat (4) send_cmd(FUNC_ASSIGN, 10'd7);
        send_cmd(FUNC_CREATE, 10'd7);
        send_cmd(FUNC_ASSIGN, 10'd7);
        send_cmd(FUNC_QUERY, 10'd0);       // high follows the new block size
        send_cmd(FUNC_DELETE, 10'd7);
        send_cmd(FUNC_ASSIGN, 10'd7);

        // product leaves 16 bits
        set_config(16'hFFFF, 16'hFFFF);
        send_cmd(FUNC_CREATE, 10'd1023);
        send_cmd(FUNC_QUERY, 10'd1023);

        // share factor zero acts as one; block size zero wraps high round to low - 1, here 65535
        set_config(16'd0, 16'd0);
        send_cmd(FUNC_CREATE, 10'd1022);
        send_cmd(FUNC_ASSIGN, 10'd1022);
        send_cmd(FUNC_ASSIGN, 10'd1023);
        send_cmd(FUNC_ASSIGN, 10'd1023);

        // --- random phases ---
        rnd_sf = $urandom_range(2, 64);
        sf_set = '{16'd4, 16'hFFFF, 16'd1, SEQ_W'(rnd_sf), 16'd3};
        bs_set = '{16'd3, 16'd1, 16'hFFFF, SEQ_W'(65535 / rnd_sf), 16'd5};
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_config(sf_set[p], bs_set[p]);
            if (p == NUM_PHASES - 1)
                quiet = 1'b1;
            if (p == 1) begin
                // long receiver hold-off in mid-phase, sender keeps offering
                run_random(PHASE_ITEMS / 2);
                hold_req = 1'b1;
                run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                run_random(PHASE_ITEMS);
            end
        end

        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run: %0d commands sent, %0d results checked, %0d register writes,",
                 cmds_sent, checked, cfg_writes);
        $display("     %0d long output hold-off(s), share/block settings from 0 up to 65535",
                 holds_done);
        if (fail_count == 0 && pending == 0)
            $display("nat_sequence_block_allocator_tb: done, clean");
        else
            $display("nat_sequence_block_allocator_tb: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
src/nsba_pkg.sv
src/nsba_ram.sv
src/nsba_mod.sv
src/nat_sequence_block_allocator.sv
tb/nsba_checker.sv
tb/nat_sequence_block_allocator_tb.sv
